### sv/assert_macros.svh
// Assertion macros shared by the RTL, compiled out when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every aclk edge outside reset.
`define MNPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check on every aclk edge, reset included.
`define MNPG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define MNPG_ASSERT(lbl, prop, msg)
`define MNPG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/mnpg_pkg.sv
// Shared constants, types and helpers of the mono voice controller.
package mnpg_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam int KEY_W   = 7;
    localparam int BEND_W  = 14;
    localparam int PITCH_W = 17;

    // event codes
    localparam logic [2:0] MODE_NOTE_ON  = 3'd0;
    localparam logic [2:0] MODE_NOTE_OFF = 3'd1;
    localparam logic [2:0] MODE_BEND     = 3'd2;
    localparam logic [2:0] MODE_ALL_OFF  = 3'd3;
    localparam logic [2:0] MODE_TICK     = 3'd4;

    // register indexes
    localparam logic [1:0] CFG_LISTEN_CHANNEL = 2'd0;
    localparam logic [1:0] CFG_GLIDE_RATE     = 2'd1;
    localparam logic [1:0] CFG_DETUNE_STEP    = 2'd2;

    localparam logic [KEY_W-1:0]          KEY_RESET   = 7'd69;
    localparam logic signed [PITCH_W-1:0] PITCH_RESET = 17'sd17664;
    localparam logic [8:0]                DETUNE_MAX  = 9'd256;
    localparam logic [4:0]                CHAN_MAX    = 5'd16;

    // command to the note stack, valid for one cycle
    typedef struct packed {
        logic             push;
        logic             remove;
        logic             clear;
        logic [KEY_W-1:0] key;
    } mnpg_stack_cmd_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             push;
        logic             remove;
        logic             found;
        logic             full;
        logic [KEY_W-1:0] key;
    } mnpg_cell_ctrl_t;

    // key * 256 + bend
    function automatic logic signed [PITCH_W-1:0] pitch_of(
        input logic [KEY_W-1:0]         key,
        input logic signed [BEND_W-1:0] bend
    );
        pitch_of = $signed({{(PITCH_W-KEY_W-8){1'b0}}, key, 8'h00})
                 + $signed({{(PITCH_W-BEND_W){bend[BEND_W-1]}}, bend});
    endfunction

endpackage

### sv/mono_note_priority_glide_core.sv
// Top level of the monophonic last-note-priority voice controller with glide.
//
// Input channel (s_axis_*): one event per beat. tuser carries the event kind
// (note on, note off, pitch bend, all notes off, millisecond tick); tdata
// carries channel, key, velocity, bend and tick time. Every event gives
// exactly one result beat on m_axis_*: gate, retrigger and release pulses,
// velocity, and the centre pitch with four detuned side pitches (Q8
// semitones, 17-bit two's complement).
// An event runs through execute, then a fall step for a note off that falls
// back to a held key or a glide step for a tick, then done, which loads the
// output register. A new event is taken once the controller is back in idle;
// the extra step comes from the pass over the cell row (stack update, then top
// read) and the registered rate * elapsed-time multiply. The result sits in an
// output register, so a stalled receiver holds the beat there while the next
// event is already being worked on; a second finished result waits in the last
// sequencer step until the register frees. Reset (aresetn low, synchronous)
// empties the stack, drops the gate, sets the pitch to note 69 and clears the
// configuration registers. Config writes (cfg_we) take effect at once and are
// to be made by the user while no event is open; the block does not enforce it.
module mono_note_priority_glide_core import mnpg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] channel, [11:5] key, [18:12] strike, [32:19] bend_amount,
    // [64:33] time_ms, [71:65] zero
    input  logic [71:0] s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] gate, [1] retrigger, [2] release_res, [9:3] level,
    // [26:10] pitch_center, [43:27] pitch_down_one, [60:44] pitch_up_one,
    // [77:61] pitch_down_two, [94:78] pitch_up_two, [95] zero
    output logic [95:0] m_axis_tdata
);

    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_FALL  = 5'b00100,
        ST_GLIDE = 5'b01000,
        ST_DONE  = 5'b10000
    } st_t;

    st_t state_reg;

    // configuration
    logic [4:0]  listen_reg;
    logic [15:0] rate_reg;
    logic [8:0]  detune_reg;

    // voice state
    logic                      held_reg;
    logic [KEY_W-1:0]          tkey_reg;
    logic signed [BEND_W-1:0]  bend_reg;
    logic signed [PITCH_W-1:0] cur_reg;
    logic signed [PITCH_W-1:0] tgt_reg;
    logic [6:0]                level_reg;
    logic [31:0]               last_tick_reg;
    logic                      retrig_reg;
    logic                      rel_reg;

    // captured event
    logic [2:0]               mode_reg;
    logic [4:0]               chan_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [6:0]               strike_reg;
    logic signed [BEND_W-1:0] bend_in_reg;
    logic [31:0]              time_reg;

    // glide step
    logic [47:0] prod_reg;
    logic [17:0] mag_reg;
    logic        up_reg;
    logic        snap_reg;
    logic        eq_reg;

    logic        m_valid_reg;
    logic [95:0] m_data_reg;

    // combinational helpers
    logic [2:0]                mode_eff;
    logic [4:0]                listen_eff;
    logic                      chan_ok;
    logic                      all_off_ok;
    logic [31:0]               dt;
    logic signed [17:0]        diff;
    logic                      glide_hit;
    logic signed [PITCH_W-1:0] on_pitch;
    logic signed [PITCH_W-1:0] bend_pitch;
    logic signed [PITCH_W-1:0] fall_pitch;
    logic [PITCH_W-1:0]        d1;
    logic [PITCH_W-1:0]        d2;
    logic                      out_free;

    mnpg_stack_cmd_t  stk_cmd;
    logic [CNT_W-1:0] stk_count;
    logic [CNT_W-1:0] stk_count_after;
    logic [KEY_W-1:0] stk_top;

    function automatic logic s_mode_is_on_zero();
        s_mode_is_on_zero = (mode_reg == MODE_NOTE_ON) && (strike_reg == 7'd0);
    endfunction

    // zero velocity note on is a note off
    assign mode_eff   = (s_mode_is_on_zero()) ? MODE_NOTE_OFF : mode_reg;
    assign listen_eff = (listen_reg > CHAN_MAX) ? 5'd0 : listen_reg;
    assign chan_ok    = (listen_eff == 5'd0) || (chan_reg == listen_eff);
    assign all_off_ok = (chan_reg == 5'd0) || chan_ok;

    // first tick after reset counts as no elapsed time; wraps mod 2^32
    assign dt   = (last_tick_reg == 32'd0) ? 32'd0 : (time_reg - last_tick_reg);
    assign diff = {tgt_reg[PITCH_W-1], tgt_reg} - {cur_reg[PITCH_W-1], cur_reg};
    assign glide_hit = (|prod_reg[47:18]) || (mag_reg <= prod_reg[17:0]);

    assign on_pitch   = pitch_of(key_reg, bend_reg);
    assign bend_pitch = pitch_of(tkey_reg, bend_in_reg);
    assign fall_pitch = pitch_of(stk_top, bend_reg);

    // side pitches: detune clamped to one semitone
    assign d1 = (detune_reg > DETUNE_MAX) ? PITCH_W'(DETUNE_MAX)
                                          : PITCH_W'(detune_reg);
    assign d2 = {d1[PITCH_W-2:0], 1'b0};

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        stk_cmd.key    = key_reg;
        stk_cmd.push   = (state_reg == ST_EXEC) && (mode_eff == MODE_NOTE_ON) && chan_ok;
        stk_cmd.remove = (state_reg == ST_EXEC) && (mode_eff == MODE_NOTE_OFF) && chan_ok;
        stk_cmd.clear  = (state_reg == ST_EXEC) && (mode_eff == MODE_ALL_OFF) && all_off_ok;
    end

    mnpg_stack u_stack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (stk_cmd),
        .count       (stk_count),
        .count_after (stk_count_after),
        .top_key     (stk_top)
    );

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_reg <= '0;
            rate_reg   <= '0;
            detune_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LISTEN_CHANNEL: listen_reg <= cfg_wdata[4:0];
                CFG_GLIDE_RATE:     rate_reg   <= cfg_wdata;
                CFG_DETUNE_STEP:    detune_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // event capture, glide operands and output data (payload, no reset)
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid) begin
            mode_reg    <= s_axis_tuser;
            chan_reg    <= s_axis_tdata[4:0];
            key_reg     <= s_axis_tdata[11:5];
            strike_reg  <= s_axis_tdata[18:12];
            bend_in_reg <= s_axis_tdata[32:19];
            time_reg    <= s_axis_tdata[64:33];
        end
        if (state_reg == ST_EXEC) begin
            prod_reg <= dt * rate_reg;
            mag_reg  <= diff[17] ? 18'(-diff) : 18'(diff);
            up_reg   <= !diff[17];
            snap_reg <= (rate_reg == 16'd0) || (dt == 32'd0);
            eq_reg   <= (cur_reg == tgt_reg);
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= {1'b0,
                           cur_reg + d2, cur_reg - d2,
                           cur_reg + d1, cur_reg - d1,
                           cur_reg, level_reg, rel_reg, retrig_reg, held_reg};
        end
    end

    // sequencer and voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= 1'b0;
            tkey_reg      <= KEY_RESET;
            bend_reg      <= '0;
            cur_reg       <= PITCH_RESET;
            tgt_reg       <= PITCH_RESET;
            level_reg     <= '0;
            last_tick_reg <= '0;
            retrig_reg    <= 1'b0;
            rel_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // the result loads the output register if empty or as its beat leaves
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (mode_eff)
                        MODE_NOTE_ON: begin
                            state_reg <= ST_DONE;
                            if (chan_ok) begin
                                tkey_reg  <= key_reg;
                                level_reg <= strike_reg;
                                tgt_reg   <= on_pitch;
                                if (!held_reg || rate_reg == 16'd0) begin
                                    cur_reg <= on_pitch;
                                end
                                held_reg   <= 1'b1;
                                retrig_reg <= 1'b1;
                            end
                        end
                        MODE_NOTE_OFF: begin
                            if (chan_ok && stk_count_after != '0) begin
                                state_reg <= ST_FALL;   // legato to new top
                            end else begin
                                state_reg <= ST_DONE;
                                if (chan_ok) begin
                                    held_reg <= 1'b0;
                                    rel_reg  <= 1'b1;
                                end
                            end
                        end
                        MODE_BEND: begin
                            state_reg <= ST_DONE;
                            if (chan_ok) begin
                                bend_reg <= bend_in_reg;
                                if (held_reg) begin
                                    tgt_reg <= bend_pitch;
                                    if (rate_reg == 16'd0) begin
                                        cur_reg <= bend_pitch;
                                    end
                                end
                            end
                        end
                        MODE_ALL_OFF: begin
                            state_reg <= ST_DONE;
                            if (all_off_ok && held_reg) begin
                                held_reg <= 1'b0;
                                rel_reg  <= 1'b1;
                            end
                        end
                        MODE_TICK: begin
                            last_tick_reg <= time_reg;
                            state_reg     <= ST_GLIDE;
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_FALL: begin
                    tkey_reg  <= stk_top;
                    tgt_reg   <= fall_pitch;
                    state_reg <= ST_DONE;
                end
                ST_GLIDE: begin
                    // step saturates at the target
                    if (!eq_reg) begin
                        if (snap_reg || glide_hit) begin
                            cur_reg <= tgt_reg;
                        end else if (up_reg) begin
                            cur_reg <= cur_reg + $signed(prod_reg[PITCH_W-1:0]);
                        end else begin
                            cur_reg <= cur_reg - $signed(prod_reg[PITCH_W-1:0]);
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        retrig_reg  <= 1'b0;
                        rel_reg     <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // gate and stack fill move together
    `MNPG_ASSERT(a_held_matches_count, held_reg == (stk_count != '0), "gate vs stack fill")
    `MNPG_ASSERT(a_count_in_range, stk_count <= CNT_W'(STACK_DEPTH), "stack count overflow")
    `MNPG_ASSERT(a_pulses_exclusive, m_axis_tvalid |-> !(&m_axis_tdata[2:1]), "both pulses")
    `MNPG_ASSERT(a_take_exec, s_axis_tvalid && s_axis_tready |=> state_reg == ST_EXEC, "no exec")
    `MNPG_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_axis_tvalid, "valid after reset")

endmodule

### sv/mnpg_cell.sv
// Stack slot: holds and matches a key; shifts down on remove, repeat or full push.
module mnpg_cell import mnpg_pkg::*; (
    input  logic                  aclk,
    input  mnpg_cell_ctrl_t       ctrl,
    input  logic                  valid,
    input  logic                  write_sel,
    input  logic                  hit_in,
    input  logic [KEY_W-1:0]      upper_key,
    output logic                  hit_out,
    output logic [KEY_W-1:0]      key_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             match;
    logic             shift;

    assign match   = valid && (key_reg == ctrl.key);
    assign hit_out = hit_in | match;
    assign key_out = key_reg;

    // found: close the gap above the hit; full push: everything slides down
    assign shift = (ctrl.push | ctrl.remove)
                 & (ctrl.found ? hit_out : (ctrl.push & ctrl.full));

    always_comb begin
        priority if (write_sel) begin
            key_next = ctrl.key;
        end else if (shift) begin
            key_next = upper_key;
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

### sv/mnpg_stack.sv
// Last-note-priority stack built as a row of cells with a fill count.
module mnpg_stack import mnpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mnpg_stack_cmd_t       cmd,
    output logic [CNT_W-1:0]      count,
    output logic [CNT_W-1:0]      count_after,
    output logic [KEY_W-1:0]      top_key
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] found_ext;
    logic [CNT_W-1:0] add_ext;
    logic [IDX_W-1:0] top_idx;
    logic             found;
    logic             full;
    logic [STACK_DEPTH:0] hit;
    logic [KEY_W-1:0] key_q [STACK_DEPTH+1];
    mnpg_cell_ctrl_t  ctrl;

    assign hit[0]             = 1'b0;
    assign key_q[STACK_DEPTH] = '0;
    assign found              = hit[STACK_DEPTH];
    assign full               = (count_reg == CNT_W'(STACK_DEPTH));

    assign ctrl.push   = cmd.push;
    assign ctrl.remove = cmd.remove;
    assign ctrl.found  = found;
    assign ctrl.full   = full;
    assign ctrl.key    = cmd.key;

    // a push lands on top; if it moved or evicted a key, top is one lower
    assign wr_idx = (found || full) ? (count_reg - CNT_W'(1)) : count_reg;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        mnpg_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .valid     (CNT_W'(i) < count_reg),
            .write_sel (cmd.push && (wr_idx == CNT_W'(i))),
            .hit_in    (hit[i]),
            .upper_key (key_q[i+1]),
            .hit_out   (hit[i+1]),
            .key_out   (key_q[i])
        );
    end

    assign found_ext = {{(CNT_W-1){1'b0}}, found};
    assign add_ext   = {{(CNT_W-1){1'b0}}, (!found && !full)};

    always_comb begin
        priority if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.remove) begin
            count_next = count_reg - found_ext;
        end else if (cmd.push) begin
            count_next = count_reg + add_ext;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign top_idx     = IDX_W'(count_reg - CNT_W'(1));
    assign top_key     = key_q[{1'b0, top_idx}];
    assign count       = count_reg;
    assign count_after = count_next;

endmodule

### tb/mono_note_priority_glide_core_test.sv
// Self-checking testbench for the mono last-note-priority voice controller with glide.
module mono_note_priority_glide_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mnpg_pkg::*;

    // Event kinds past tick are ignored by the block; named here for the stimulus.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // Cycles with no beat on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 110;

    // Input beat, packed as on s_axis_tdata (lowest field last).
    typedef struct packed {
        logic [6:0]         pad;
        logic [31:0]        ms;
        logic signed [13:0] bend;
        logic [6:0]         vel;
        logic [6:0]         key;
        logic [4:0]         chan;
    } midi_evt_t;

    // Result beat, packed as on m_axis_tdata.
    typedef struct packed {
        logic        pad;
        logic [16:0] up_two;
        logic [16:0] down_two;
        logic [16:0] up_one;
        logic [16:0] down_one;
        logic [16:0] center;
        logic [6:0]  level;
        logic        rel;
        logic        retrig;
        logic        gate;
    } voice_t;

    // One line of the directed plan: a register write or an event,
    // optionally with its result typed in by hand.
    typedef struct {
        bit          reg_write;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        logic [2:0]  mode;
        midi_evt_t   ev;
        bit          typed;
        voice_t      want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // channel, key, strike, bend_amount, time_ms, zero
    logic [2:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // gate, retrigger, release_res, level, pitch_center, pitch_down_one,
    // pitch_up_one, pitch_down_two, pitch_up_two, zero
    logic [95:0] m_axis_tdata;

    mono_note_priority_glide_core uut (
        .aclk, .aresetn,
        .cfg_we, .cfg_index, .cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Voice predictor: own copy of the settings and of the voice state.
    // ------------------------------------------------------------------
    logic [4:0]       listen_ch = '0;
    logic [15:0]      rate = '0;
    logic [8:0]       detune = '0;

    logic [KEY_W-1:0] stack [STACK_DEPTH];
    int unsigned      depth_cnt = 0;
    bit               held = 1'b0;
    logic [KEY_W-1:0] tgt_key = KEY_RESET;
    int               bend_q = 0;
    int               cur_p = int'(PITCH_RESET);
    int               tgt_p = int'(PITCH_RESET);
    logic [6:0]       lvl = '0;
    logic [31:0]      prev_tick = '0;

    voice_t expected_voice [$];
    int     errors = 0;
    int     tx_gap_pct = 0;
    int     rx_stall_pct = 0;
    logic [31:0] clock_ms = '0;

    // a listen channel above sixteen behaves as omni
    function automatic bit chan_match(input logic [4:0] ch);
        logic [4:0] lc;
        lc = (listen_ch > CHAN_MAX) ? 5'd0 : listen_ch;
        return lc == 5'd0 || ch == lc;
    endfunction

    function automatic int key_pitch(input logic [KEY_W-1:0] k);
        return int'(k) * 256 + bend_q;
    endfunction

    function automatic void drop_key(input logic [KEY_W-1:0] k);
        int i, j;
        for (i = 0; i < depth_cnt; i++) begin
            if (stack[i] == k) begin
                for (j = i + 1; j < depth_cnt; j++)
                    stack[j-1] = stack[j];
                depth_cnt--;
                return;
            end
        end
    endfunction

    // a repeated key goes to the top; a full stack loses its oldest key
    function automatic void push_key(input logic [KEY_W-1:0] k);
        int i;
        drop_key(k);
        if (depth_cnt >= STACK_DEPTH) begin
            for (i = 1; i < STACK_DEPTH; i++)
                stack[i-1] = stack[i];
            depth_cnt = STACK_DEPTH - 1;
        end
        stack[depth_cnt] = k;
        depth_cnt++;
    endfunction

    // Applies one event to the predicted state and returns the result beat.
    function automatic voice_t advance_voice(input logic [2:0] mode_in, input midi_evt_t ev);
        logic [2:0]      op;
        bit              was;
        logic [31:0]     dt;
        int              diff;
        int              d;
        longint unsigned mag, span;
        voice_t          r;
        op = mode_in;
        r = '0;
        // zero strike is a note off for that key
        if (op == MODE_NOTE_ON && ev.vel == 7'd0)
            op = MODE_NOTE_OFF;
        case (op)
            MODE_NOTE_ON: if (chan_match(ev.chan)) begin
                was = held;
                push_key(ev.key);
                tgt_key = ev.key;
                lvl = ev.vel;
                tgt_p = key_pitch(ev.key);
                // glide only from a held note; fresh notes start on pitch
                if (!was || rate == 16'd0)
                    cur_p = tgt_p;
                held = 1'b1;
                r.retrig = 1'b1;
            end
            MODE_NOTE_OFF: if (chan_match(ev.chan)) begin
                drop_key(ev.key);
                if (depth_cnt != 0) begin
                    // legato fallback: only the target moves
                    tgt_key = stack[depth_cnt-1];
                    tgt_p = key_pitch(tgt_key);
                end else begin
                    // releases even when nothing was held
                    held = 1'b0;
                    r.rel = 1'b1;
                end
            end
            MODE_BEND: if (chan_match(ev.chan)) begin
                bend_q = int'($signed(ev.bend));
                if (held) begin
                    tgt_p = key_pitch(tgt_key);
                    if (rate == 16'd0)
                        cur_p = tgt_p;
                end
            end
            MODE_ALL_OFF: if (ev.chan == 5'd0 || chan_match(ev.chan)) begin
                depth_cnt = 0;
                if (held) begin
                    held = 1'b0;
                    r.rel = 1'b1;
                end
            end
            MODE_TICK: begin
                // a stored time of zero means no tick seen yet; elapsed wraps
                dt = (prev_tick == 32'd0) ? 32'd0 : ev.ms - prev_tick;
                prev_tick = ev.ms;
                if (cur_p != tgt_p) begin
                    if (rate == 16'd0 || dt == 32'd0) begin
                        cur_p = tgt_p;
                    end else begin
                        diff = tgt_p - cur_p;
                        mag = 64'((diff < 0) ? -diff : diff);
                        span = dt * rate;
                        if (mag <= span)
                            cur_p = tgt_p;
                        else if (diff > 0)
                            cur_p += int'(span);
                        else
                            cur_p -= int'(span);
                    end
                end
            end
            default: ;
        endcase
        d = (detune > DETUNE_MAX) ? int'(DETUNE_MAX) : int'(detune);
        r.gate     = held;
        r.level    = lvl;
        r.center   = PITCH_W'(cur_p);
        r.down_one = PITCH_W'(cur_p - d);
        r.up_one   = PITCH_W'(cur_p + d);
        r.down_two = PITCH_W'(cur_p - 2 * d);
        r.up_two   = PITCH_W'(cur_p + 2 * d);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: each m_axis beat against the oldest expectation.
    // ------------------------------------------------------------------
    voice_t got, want;

    function automatic void check_field(input string name, input logic [16:0] exp_v,
                                        input logic [16:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_voice.size() == 0) begin
                $error("result beat with no event outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_voice.pop_front();
                check_field("gate", 17'(want.gate), 17'(got.gate));
                check_field("retrigger", 17'(want.retrig), 17'(got.retrig));
                check_field("release_res", 17'(want.rel), 17'(got.rel));
                check_field("level", 17'(want.level), 17'(got.level));
                check_field("pitch_center", want.center, got.center);
                check_field("pitch_down_one", want.down_one, got.down_one);
                check_field("pitch_up_one", want.up_one, got.up_one);
                check_field("pitch_down_two", want.down_two, got.down_two);
                check_field("pitch_up_two", want.up_two, got.up_two);
            end
        end
    end

    // Receiver back-pressure: now and then tready drops for a burst of random length.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: too long without a beat on either side means a hang.
    int quiet = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving helpers. Each is entered just after a rising edge.
    // ------------------------------------------------------------------

    // Present one beat, hold it until taken, then predict its result.
    task automatic send_event(input logic [2:0] mode, input midi_evt_t ev,
                              input bit typed, input voice_t typed_want);
        voice_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ev;
        s_axis_tuser  <= mode;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        predicted = advance_voice(mode, ev);
        expected_voice.push_back(typed ? typed_want : predicted);
    endtask

    // Sender gap: now and then tvalid drops for a burst of random length.
    task automatic idle_sender();
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait for every outstanding result, checked after each rising edge.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_voice.size() != 0);
    endtask

    // Register write, only with the block idle; mirrored into the predictor.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LISTEN_CHANNEL: listen_ch = val[4:0];
            CFG_GLIDE_RATE:     rate = val;
            CFG_DETUNE_STEP:    detune = val[8:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Directed plan rows.
    // ------------------------------------------------------------------
    function automatic row_t event_row(input logic [2:0] mode, input logic [4:0] ch,
                                       input logic [6:0] key, input logic [6:0] vel,
                                       input int bend, input logic [31:0] ms);
        row_t r;
        r.reg_write = 1'b0;
        r.reg_idx   = '0;
        r.reg_val   = '0;
        r.mode      = mode;
        r.ev        = '0;
        r.ev.chan   = ch;
        r.ev.key    = key;
        r.ev.vel    = vel;
        r.ev.bend   = bend[13:0];
        r.ev.ms     = ms;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    // Hand-worked result; holds with detune at zero, so all pitches agree.
    function automatic row_t typed_row(input logic [2:0] mode, input logic [4:0] ch,
                                       input logic [6:0] key, input logic [6:0] vel,
                                       input int bend, input logic [31:0] ms,
                                       input bit gate, input bit retrig, input bit rel,
                                       input logic [6:0] level, input int pitch);
        row_t r;
        r = event_row(mode, ch, key, vel, bend, ms);
        r.typed         = 1'b1;
        r.want.gate     = gate;
        r.want.retrig   = retrig;
        r.want.rel      = rel;
        r.want.level    = level;
        r.want.center   = pitch[16:0];
        r.want.down_one = pitch[16:0];
        r.want.up_one   = pitch[16:0];
        r.want.down_two = pitch[16:0];
        r.want.up_two   = pitch[16:0];
        return r;
    endfunction

    function automatic row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
        row_t r;
        r = event_row(MODE_TICK, '0, '0, '0, 0, '0);
        r.reg_write = 1'b1;
        r.reg_idx   = idx;
        r.reg_val   = val;
        return r;
    endfunction

    // Channel for a random event: mostly one the block listens to.
    function automatic logic [4:0] pick_channel();
        logic [4:0] lc;
        lc = (listen_ch > CHAN_MAX) ? 5'd0 : listen_ch;
        if (lc == 5'd0 || $urandom_range(0, 99) < 15)
            return 5'($urandom_range(0, 31));
        return lc;
    endfunction

    // Random event: plausible playing (a handful of keys, so repeats and
    // stack overflow are common, offs mostly of held keys, ticks a few ms
    // apart) mixed with noise in every field the event does not use.
    task automatic make_event(output logic [2:0] mode, output midi_evt_t ev);
        int pick;
        int b;
        ev = '0;
        ev.chan = 5'($urandom_range(0, 31));
        ev.key  = 7'($urandom_range(0, 127));
        ev.vel  = 7'($urandom_range(0, 127));
        ev.bend = 14'($urandom_range(0, 16383));
        ev.ms   = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            mode = MODE_NOTE_ON;
            ev.chan = pick_channel();
            if ($urandom_range(0, 3) != 0)
                ev.key = 7'(48 + $urandom_range(0, 11));
            ev.vel = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
        end else if (pick < 54) begin
            mode = MODE_NOTE_OFF;
            ev.chan = pick_channel();
            if (depth_cnt != 0 && $urandom_range(0, 9) < 7)
                ev.key = stack[$urandom_range(0, depth_cnt - 1)];
        end else if (pick < 62) begin
            mode = MODE_BEND;
            ev.chan = pick_channel();
            // mostly the nominal range, sometimes anything 14 bits hold
            if ($urandom_range(0, 9) < 7)
                b = int'($urandom_range(0, 12287)) - 6144;
            else
                b = int'($urandom_range(0, 16383)) - 8192;
            ev.bend = b[13:0];
        end else if (pick < 65) begin
            mode = MODE_ALL_OFF;
            ev.chan = $urandom_range(0, 1) ? 5'd0 : pick_channel();
        end else if (pick < 97) begin
            mode = MODE_TICK;
            case ($urandom_range(0, 19))
                17: clock_ms = $urandom;
                18: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20);
                19: clock_ms = '0;   // back to the first-tick case
                default: clock_ms += $urandom_range(0, 30);
            endcase
            ev.ms = clock_ms;
        end else begin
            mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed plan, then random phases under varied settings.
    // ------------------------------------------------------------------
    initial begin : stimulus
        row_t       plan [$];
        int         ph, n;
        int         set_lc, set_gr, set_dt;
        logic [2:0] mode;
        midi_evt_t  ev;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        tx_gap_pct = 20;
        rx_stall_pct = 20;

        // Reset settings: omni, instant glide, no detune.
        // First tick with time zero leaves the reset pitch (note 69).
        plan.push_back(typed_row(MODE_TICK, 5'd0, 7'd0, 7'd0, 0, 32'd0,
                                 0, 0, 0, 7'd0, 17664));
        plan.push_back(typed_row(MODE_NOTE_ON, 5'd1, 7'd127, 7'd127, 0, 32'd0,
                                 1, 1, 0, 7'd127, 32512));
        plan.push_back(typed_row(MODE_NOTE_ON, 5'd16, 7'd0, 7'd1, 0, 32'd0,
                                 1, 1, 0, 7'd1, 0));
        // unused kind with every field at all ones: nothing changes
        plan.push_back(typed_row(MODE_UNUSED_HI, 5'd31, 7'd127, 7'd127, -1, 32'hFFFF_FFFF,
                                 1, 0, 0, 7'd1, 0));
        plan.push_back(typed_row(MODE_ALL_OFF, 5'd0, 7'd0, 7'd0, 0, 32'd0,
                                 0, 0, 1, 7'd1, 0));
        // off for a key not held, stack empty: release pulses again
        plan.push_back(typed_row(MODE_NOTE_OFF, 5'd1, 7'd5, 7'd0, 0, 32'd0,
                                 0, 0, 1, 7'd1, 0));
        plan.push_back(typed_row(MODE_UNUSED_LO, 5'd0, 7'd0, 7'd0, 0, 32'd0,
                                 0, 0, 0, 7'd1, 0));
        // bend extremes, legato stack, repeated key, zero-strike note on
        plan.push_back(event_row(MODE_BEND, 5'd3, 7'd0, 7'd0, 8191, 32'd0));
        plan.push_back(event_row(MODE_NOTE_ON, 5'd2, 7'd60, 7'd64, 0, 32'd0));
        plan.push_back(event_row(MODE_NOTE_ON, 5'd2, 7'd64, 7'd100, 0, 32'd0));
        plan.push_back(event_row(MODE_NOTE_ON, 5'd2, 7'd60, 7'd90, 0, 32'd0));
        plan.push_back(event_row(MODE_NOTE_ON, 5'd2, 7'd60, 7'd0, 0, 32'd0));
        plan.push_back(event_row(MODE_BEND, 5'd2, 7'd0, 7'd0, -8192, 32'd0));
        // slow glide, detune clamped at one semitone, listen above sixteen = omni
        plan.push_back(reg_row(CFG_GLIDE_RATE, 16'd3));
        plan.push_back(reg_row(CFG_DETUNE_STEP, 16'd511));
        plan.push_back(reg_row(CFG_LISTEN_CHANNEL, 16'd20));
        plan.push_back(event_row(MODE_NOTE_ON, 5'd9, 7'd72, 7'd5, 0, 32'd0));
        plan.push_back(event_row(MODE_TICK, 5'd0, 7'd0, 7'd0, 0, 32'hFFFF_FFF0));
        plan.push_back(event_row(MODE_NOTE_OFF, 5'd9, 7'd72, 7'd0, 0, 32'd0));
        // elapsed time across the 32-bit wrap, then a partial step
        plan.push_back(event_row(MODE_TICK, 5'd0, 7'd0, 7'd0, 0, 32'd5));
        plan.push_back(event_row(MODE_TICK, 5'd0, 7'd0, 7'd0, 0, 32'd200));
        // channel filtering; all-notes-off on channel 0 always gets through
        plan.push_back(reg_row(CFG_LISTEN_CHANNEL, 16'd5));
        plan.push_back(event_row(MODE_NOTE_ON, 5'd6, 7'd10, 7'd50, 0, 32'd0));
        plan.push_back(event_row(MODE_ALL_OFF, 5'd6, 7'd0, 7'd0, 0, 32'd0));
        plan.push_back(event_row(MODE_ALL_OFF, 5'd0, 7'd0, 7'd0, 0, 32'd0));
        plan.push_back(reg_row(CFG_GLIDE_RATE, 16'd0));
        plan.push_back(event_row(MODE_NOTE_OFF, 5'd5, 7'd0, 7'd0, 0, 32'd0));

        foreach (plan[i]) begin
            if (plan[i].reg_write) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                idle_sender();
                send_event(plan[i].mode, plan[i].ev, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: low extremes, high extremes, out-of-range settings,
        // then random ones; the last phase runs with no idling at all.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin set_lc = 0;  set_gr = 0;     set_dt = 0;   end
                1: begin set_lc = 16; set_gr = 65535; set_dt = 256; end
                2: begin set_lc = 31; set_gr = 1;     set_dt = 511; end
                default: begin
                    set_lc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 31);
                    set_gr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(1, 40);
                    set_dt = $urandom_range(0, 511);
                end
            endcase
            settle();
            write_reg(CFG_LISTEN_CHANNEL, 16'(set_lc));
            write_reg(CFG_GLIDE_RATE, 16'(set_gr));
            write_reg(CFG_DETUNE_STEP, 16'(set_dt));
            if (ph == PHASES - 1) begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct = 15 * $urandom_range(0, 2);
                rx_stall_pct = 15 * $urandom_range(0, 2);
            end
            for (n = 0; n < PHASE_BEATS; n++) begin
                // sender holds off mid-phase until the pipe has emptied
                if (ph == 3 && n == PHASE_BEATS / 2)
                    settle();
                make_event(mode, ev);
                idle_sender();
                send_event(mode, ev, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
